@@ hdl/slpg_pkg.sv @@
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types and constants for the status LED pattern generator: mode codes,
// blink and pulse timing, reciprocal constants and the colour word layout.
// ----------------------------------------------------------------------------
package slpg_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PROD_W  = 2 * CHAN_W;

  // Timing in milliseconds
  localparam int unsigned HEAP_HALF_MS = 120;
  localparam int unsigned BMS_HALF_MS  = 200;
  localparam int unsigned PULSE_PERIOD = 2000;
  localparam int unsigned PULSE_HALF   = 1000;
  localparam int unsigned FULL_LEVEL   = 255;

  // Remainders stay below twice the largest divisor, so 12 low bits suffice
  localparam int unsigned REM_W   = 12;
  localparam int unsigned PHASE_W = 11;
  localparam int unsigned FOLD_W  = 10;
  localparam int unsigned SCALE_W = 18;

  // Quotient estimates t * floor(2^32 / d) >> 32, short by at most one
  localparam logic [TIME_W-1:0] RECIP_HEAP  = TIME_W'((64'd1 << TIME_W) / 64'(HEAP_HALF_MS));
  localparam logic [TIME_W-1:0] RECIP_BMS   = TIME_W'((64'd1 << TIME_W) / 64'(BMS_HALF_MS));
  localparam logic [TIME_W-1:0] RECIP_PULSE = TIME_W'((64'd1 << TIME_W) / 64'(PULSE_PERIOD));

  // Exact divide by 1000 for values below 2^18: ceil(2^28 / 1000)
  localparam int unsigned LEVEL_SHIFT   = 28;
  localparam int unsigned LEVEL_RECIP_W = 19;
  localparam int unsigned LEVEL_PROD_W  = SCALE_W + LEVEL_RECIP_W;
  localparam logic [LEVEL_RECIP_W-1:0] LEVEL_RECIP =
    LEVEL_RECIP_W'(((64'd1 << LEVEL_SHIFT) + 64'(PULSE_HALF) - 64'd1) / 64'(PULSE_HALF));

  // Status mode codes
  typedef enum logic [MODE_W-1:0] {
    MODE_BOOT        = 3'd0,
    MODE_FAULT_BMS   = 3'd1,
    MODE_FAULT_MPPT  = 3'd2,
    MODE_SOC_LOW     = 3'd3,
    MODE_SHORE_POWER = 3'd4,
    MODE_ACTIVE      = 3'd5,
    MODE_IDLE_OK     = 3'd6,
    MODE_OFF         = 3'd7
  } mode_t;

  // Colour word, red in the lowest byte
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  // Blink and pulse phase of one sample
  typedef struct packed {
    mode_t              mode;
    logic               alert;
    logic               heap_on;
    logic               bms_on;
    logic               mppt_on;
    logic [PHASE_W-1:0] ph;
  } phase_t;

  localparam rgb_t COL_BLACK   = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
  localparam rgb_t COL_WHITE   = '{blue: 8'd255, green: 8'd255, red: 8'd255};
  localparam rgb_t COL_MAGENTA = '{blue: 8'd255, green: 8'd0,   red: 8'd255};
  localparam rgb_t COL_RED     = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
  localparam rgb_t COL_ORANGE  = '{blue: 8'd0,   green: 8'd90,  red: 8'd255};
  localparam rgb_t COL_AMBER   = '{blue: 8'd0,   green: 8'd150, red: 8'd255};
  localparam rgb_t COL_SHORE   = '{blue: 8'd255, green: 8'd60,  red: 8'd0};
  localparam rgb_t COL_IDLE    = '{blue: 8'd0,   green: 8'd80,  red: 8'd0};

endpackage

@@ hdl/status_led_pattern_generator_top.sv @@
// ----------------------------------------------------------------------------
// status_led_pattern_generator_top
// Status LED colour generator: one time sample in, one dimmed RGB word out.
// ----------------------------------------------------------------------------
// Takes one time sample per clock and returns its dimmed colour from the
// output register; the rate is one word per cycle while the sink takes words.
// The six register stages are: reciprocal multiplies for the blink and pulse
// quotients, remainder correction, pulse fold and scale, triangle divide and
// colour select, brightness multiply, and the divide by 255 into the output
// register. Each stage stalls only when it is full and the stage after it is
// blocked, so empty stages keep filling while a result waits. Brightness is
// sampled at the multiply stage and should be written only while no word is
// in flight; it resets to full scale (255).
// ----------------------------------------------------------------------------
module status_led_pattern_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,     // [31:0] elapsed_ms
  input  logic [3:0]  s_axis_tuser,     // [2:0] status_mode, [3] heap_alert
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,     // [7:0] red, [15:8] green, [23:16] blue
  input  logic        brightness_we,
  input  logic [7:0]  brightness_wdata
);
  import slpg_pkg::*;

  logic               ph_valid, ph_ready;
  phase_t             phase;
  logic               col_valid, col_ready;
  rgb_t               base;
  rgb_t               colour;
  logic [CHAN_W-1:0]  brightness;

  // Brightness register
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= CHAN_W'(FULL_LEVEL);
    end else if (brightness_we) begin
      brightness <= brightness_wdata;
    end
  end

  slpg_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .elapsed_ms  (s_axis_tdata),
    .status_mode (mode_t'(s_axis_tuser[MODE_W-1:0])),
    .heap_alert  (s_axis_tuser[MODE_W]),
    .out_valid   (ph_valid),
    .out_ready   (ph_ready),
    .phase       (phase)
  );

  slpg_colour u_colour (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ph_valid),
    .in_ready  (ph_ready),
    .phase     (phase),
    .out_valid (col_valid),
    .out_ready (col_ready),
    .base      (base)
  );

  slpg_dim u_dim (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (col_valid),
    .in_ready   (col_ready),
    .base       (base),
    .brightness (brightness),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .colour     (colour)
  );

  assign m_axis_tdata = colour;

endmodule

@@ hdl/slpg_phase.sv @@
// ----------------------------------------------------------------------------
// slpg_phase
// Two-stage divider front end: quotient estimates by reciprocal multiply, then
// remainder correction giving blink parities and the pulse phase.
// ----------------------------------------------------------------------------
module slpg_phase (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [slpg_pkg::TIME_W-1:0]   elapsed_ms,
  input  slpg_pkg::mode_t               status_mode,
  input  logic                          heap_alert,
  output logic                          out_valid,
  input  logic                          out_ready,
  output slpg_pkg::phase_t              phase
);
  import slpg_pkg::*;

  logic [2*TIME_W-1:0] prod_heap, prod_bms, prod_pulse;

  // Stage A registers
  logic              va;
  logic [REM_W-1:0]  t_lo;
  mode_t             mode_a;
  logic              alert_a;
  logic [REM_W-1:0]  qe_heap, qe_bms, qe_pulse;

  // Stage B logic
  logic [REM_W-1:0]  m_heap, m_bms, m_pulse;
  logic [REM_W-1:0]  r_heap, r_bms, r_pulse, ph_full;
  logic              c_heap, c_bms, c_pulse;
  logic [1:0]        q_bms;
  logic              en_a, en_b;

  // Stage B registers
  logic              vb;
  phase_t            phase_b;

  assign en_b     = !vb || out_ready;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  // Estimate quotients
  assign prod_heap  = 64'(elapsed_ms) * 64'(RECIP_HEAP);
  assign prod_bms   = 64'(elapsed_ms) * 64'(RECIP_BMS);
  assign prod_pulse = 64'(elapsed_ms) * 64'(RECIP_PULSE);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      t_lo     <= elapsed_ms[REM_W-1:0];
      mode_a   <= status_mode;
      alert_a  <= heap_alert;
      qe_heap  <= prod_heap[TIME_W +: REM_W];
      qe_bms   <= prod_bms[TIME_W +: REM_W];
      qe_pulse <= prod_pulse[TIME_W +: REM_W];
    end
  end

  // Correct remainders; only the low bits matter as each stays below 2*d
  assign m_heap  = qe_heap  * REM_W'(HEAP_HALF_MS);
  assign m_bms   = qe_bms   * REM_W'(BMS_HALF_MS);
  assign m_pulse = qe_pulse * REM_W'(PULSE_PERIOD);

  assign r_heap  = t_lo - m_heap;
  assign r_bms   = t_lo - m_bms;
  assign r_pulse = t_lo - m_pulse;

  assign c_heap  = r_heap  >= REM_W'(HEAP_HALF_MS);
  assign c_bms   = r_bms   >= REM_W'(BMS_HALF_MS);
  assign c_pulse = r_pulse >= REM_W'(PULSE_PERIOD);

  // The 400 ms blink is bit one of the 200 ms quotient
  assign q_bms   = qe_bms[1:0] + {1'b0, c_bms};
  assign ph_full = c_pulse ? (r_pulse - REM_W'(PULSE_PERIOD)) : r_pulse;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      phase_b.mode    <= mode_a;
      phase_b.alert   <= alert_a;
      phase_b.heap_on <= qe_heap[0] ^ c_heap;
      phase_b.bms_on  <= q_bms[0];
      phase_b.mppt_on <= q_bms[1];
      phase_b.ph      <= ph_full[PHASE_W-1:0];
    end
  end

  assign out_valid = vb;
  assign phase     = phase_b;

endmodule

@@ hdl/slpg_colour.sv @@
// ----------------------------------------------------------------------------
// slpg_colour
// Two-stage colour selection: fold and scale the pulse phase, divide it to a
// triangle level, then pick the base colour for the mode and alert.
// ----------------------------------------------------------------------------
module slpg_colour (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  slpg_pkg::phase_t  phase,
  output logic              out_valid,
  input  logic              out_ready,
  output slpg_pkg::rgb_t    base
);
  import slpg_pkg::*;

  logic                     en_c, en_d;
  logic                     down;
  logic [FOLD_W-1:0]        fold;
  logic [SCALE_W-1:0]       scaled;

  // Stage C registers
  logic                     vc;
  logic [SCALE_W-1:0]       scaled_c;
  logic                     down_c;
  mode_t                    mode_c;
  logic                     alert_c, heap_c, bms_c, mppt_c;

  // Stage D logic and registers
  logic [LEVEL_PROD_W-1:0]  lvl_prod;
  logic [CHAN_W-1:0]        lvl_q, level;
  rgb_t                     base_next;
  logic                     vd;
  rgb_t                     base_d;

  assign en_d     = !vd || out_ready;
  assign en_c     = !vc || en_d;
  assign in_ready = en_c;

  // Fold the second half of the period and scale by 255
  assign down   = phase.ph >= PHASE_W'(PULSE_HALF);
  assign fold   = down ? FOLD_W'(phase.ph - PHASE_W'(PULSE_HALF)) : FOLD_W'(phase.ph);
  assign scaled = (SCALE_W'(fold) << CHAN_W) - SCALE_W'(fold);

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en_c) begin
      vc <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      scaled_c <= scaled;
      down_c   <= down;
      mode_c   <= phase.mode;
      alert_c  <= phase.alert;
      heap_c   <= phase.heap_on;
      bms_c    <= phase.bms_on;
      mppt_c   <= phase.mppt_on;
    end
  end

  // Divide by 1000 and mirror on the falling half
  assign lvl_prod = LEVEL_PROD_W'(scaled_c) * LEVEL_PROD_W'(LEVEL_RECIP);
  assign lvl_q    = lvl_prod[LEVEL_SHIFT +: CHAN_W];
  assign level    = down_c ? (CHAN_W'(FULL_LEVEL) - lvl_q) : lvl_q;

  // Pick the base colour; the alert wins over every mode
  always_comb begin
    base_next = COL_BLACK;
    if (alert_c) begin
      base_next = heap_c ? COL_MAGENTA : COL_BLACK;
    end else begin
      unique case (mode_c)
        MODE_BOOT:        base_next = COL_WHITE;
        MODE_FAULT_BMS:   base_next = bms_c ? COL_RED : COL_BLACK;
        MODE_FAULT_MPPT:  base_next = mppt_c ? COL_ORANGE : COL_BLACK;
        MODE_SOC_LOW:     base_next = COL_AMBER;
        MODE_SHORE_POWER: base_next = COL_SHORE;
        MODE_ACTIVE: begin
          base_next       = COL_BLACK;
          base_next.green = level;
        end
        MODE_IDLE_OK:     base_next = COL_IDLE;
        MODE_OFF:         base_next = COL_BLACK;
        default:          base_next = COL_BLACK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en_d) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      base_d <= base_next;
    end
  end

  assign out_valid = vd;
  assign base      = base_d;

endmodule

@@ hdl/slpg_dim.sv @@
// ----------------------------------------------------------------------------
// slpg_dim
// Two-stage dimmer: multiply each channel by the brightness, then divide the
// products by 255 with truncation into the output register.
// ----------------------------------------------------------------------------
module slpg_dim (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  slpg_pkg::rgb_t               base,
  input  logic [slpg_pkg::CHAN_W-1:0]  brightness,
  output logic                         out_valid,
  input  logic                         out_ready,
  output slpg_pkg::rgb_t               colour
);
  import slpg_pkg::*;

  logic               en_e, en_f;
  logic               ve, vf;
  logic [PROD_W-1:0]  p_red, p_green, p_blue;
  rgb_t               colour_next, colour_f;

  // Exact x / 255 for any x up to 255 * 255
  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W-1:0] s;
    s = x + (x >> CHAN_W) + PROD_W'(1);
    return s[CHAN_W +: CHAN_W];
  endfunction

  assign en_f     = !vf || out_ready;
  assign en_e     = !ve || en_f;
  assign in_ready = en_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en_e) begin
      ve <= in_valid;
    end
  end

  // Scale each channel
  always_ff @(posedge clk) begin
    if (en_e) begin
      p_red   <= PROD_W'(base.red)   * PROD_W'(brightness);
      p_green <= PROD_W'(base.green) * PROD_W'(brightness);
      p_blue  <= PROD_W'(base.blue)  * PROD_W'(brightness);
    end
  end

  assign colour_next.red   = div255(p_red);
  assign colour_next.green = div255(p_green);
  assign colour_next.blue  = div255(p_blue);

  // Output register; holds while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en_f) begin
      vf <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      colour_f <= colour_next;
    end
  end

  assign out_valid = vf;
  assign colour    = colour_f;

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the status LED pattern generator.
// ----------------------------------------------------------------------------
// Drives time samples into the stream input and compares every colour word on
// the stream output with a local predictor. The predictor covers blink phases,
// the pulse triangle and brightness dimming. The run opens with directed
// samples at the reset brightness. It then steps through several brightness
// settings. Each setting is written only while the pipe is empty, and gets
// random samples. Both stream sides pause at random, with some burst stretches.
// ----------------------------------------------------------------------------
module tb;
  import slpg_pkg::*;

  localparam int unsigned HEAP_MS   = 120;
  localparam int unsigned BMS_MS    = 200;
  localparam int unsigned MPPT_MS   = 400;
  localparam int unsigned PULSE_MS  = 2000;
  localparam int unsigned HALF_MS   = 1000;
  localparam int unsigned FULL      = 255;
  localparam int unsigned N_PHASES  = 8;
  localparam int unsigned PHASE_LEN = 200;
  localparam int unsigned SETTLE    = 12;
  localparam int unsigned LIMIT     = 400000;

  // Holds due colour words and the brightness they are dimmed with
  class colour_scoreboard;
    rgb_t        due_q[$];
    logic [7:0]  level;
    int unsigned errors;
    int unsigned words;

    function new();
      level  = 8'd255;
      errors = 0;
      words  = 0;
    endfunction

    function logic [7:0] dim(int unsigned c);
      return 8'((c * level) / FULL);
    endfunction

    function rgb_t colour_of(logic [31:0] t, mode_t mode, logic alert);
      int unsigned tt;
      int unsigned ph;
      int unsigned r;
      int unsigned g;
      int unsigned b;
      rgb_t        c;
      tt = t;
      r  = 0;
      g  = 0;
      b  = 0;
      if (alert) begin
        if (((tt / HEAP_MS) & 1) != 0) begin
          r = 255;
          b = 255;
        end
      end else begin
        case (mode)
          MODE_BOOT: begin
            r = 255;
            g = 255;
            b = 255;
          end
          MODE_FAULT_BMS: begin
            if (((tt / BMS_MS) & 1) != 0) r = 255;
          end
          MODE_FAULT_MPPT: begin
            if (((tt / MPPT_MS) & 1) != 0) begin
              r = 255;
              g = 90;
            end
          end
          MODE_SOC_LOW: begin
            r = 255;
            g = 150;
          end
          MODE_SHORE_POWER: begin
            g = 60;
            b = 255;
          end
          MODE_ACTIVE: begin
            // Rising half then falling half of the triangle
            ph = tt % PULSE_MS;
            if (ph < HALF_MS) g = ph * FULL / HALF_MS;
            else g = FULL - (ph - HALF_MS) * FULL / HALF_MS;
          end
          MODE_IDLE_OK: begin
            g = 80;
          end
          default: begin
          end
        endcase
      end
      c.red   = dim(r);
      c.green = dim(g);
      c.blue  = dim(b);
      return c;
    endfunction

    function void note_sample(logic [31:0] t, mode_t mode, logic alert);
      due_q.push_back(colour_of(t, mode, alert));
    endfunction

    task flag_error(string msg);
      errors++;
      if (errors <= 30) $display("ERROR: %s", msg);
    endtask

    task check_word(rgb_t got);
      rgb_t want;
      words++;
      if (due_q.size() == 0) begin
        flag_error($sformatf("colour word %06h with nothing due", got));
      end else begin
        want = due_q.pop_front();
        if (got.red != want.red)
          flag_error($sformatf("word %0d red %0d, want %0d", words, got.red, want.red));
        if (got.green != want.green)
          flag_error($sformatf("word %0d green %0d, want %0d", words, got.green,
                               want.green));
        if (got.blue != want.blue)
          flag_error($sformatf("word %0d blue %0d, want %0d", words, got.blue, want.blue));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        brightness_we;
  logic [7:0]  brightness_wdata;

  colour_scoreboard sb = new();
  int unsigned      cycles;
  int unsigned      samples;
  int unsigned      settings;
  logic             src_burst;
  logic             sink_burst;

  status_led_pattern_generator_top dut (
    .clk              (clk),
    .rst              (rst),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .brightness_we    (brightness_we),
    .brightness_wdata (brightness_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note accepted samples first, then check accepted words
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_sample(s_axis_tdata, mode_t'(s_axis_tuser[2:0]), s_axis_tuser[3]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_word(rgb_t'(m_axis_tdata));
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still due", cycles, sb.due_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sink: stall for a drawn number of cycles, then take one word
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = sink_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // Offer one sample after a drawn gap and hold it until taken
  task send_sample(logic [31:0] t, mode_t mode, logic alert);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= t;
    s_axis_tuser  <= {alert, mode};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    samples++;
  endtask

  // Drop valid and wait until every due word has arrived
  task drain;
    s_axis_tvalid <= 1'b0;
    while (sb.due_q.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task write_brightness(logic [7:0] value);
    brightness_we    <= 1'b1;
    brightness_wdata <= value;
    @(negedge clk);
    brightness_we    <= 1'b0;
    sb.level = value;
    settings++;
  endtask

  // Times cluster on blink edges, the pulse corners and the wrap
  function logic [31:0] pick_time();
    int unsigned half;
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 4999);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 2999);
      2: begin
        case ($urandom_range(0, 4))
          0: half = HEAP_MS;
          1: half = BMS_MS;
          2: half = MPPT_MS;
          3: half = HALF_MS;
          default: half = PULSE_MS;
        endcase
        return 32'($urandom_range(0, 1 << 20) * half + $urandom_range(0, 4) - 2);
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [7:0] level_plan[N_PHASES];
    mode_t      mode;
    cycles           = 0;
    samples          = 0;
    settings         = 0;
    src_burst        = 1'b0;
    sink_burst       = 1'b0;
    rst              = 1'b1;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = '0;
    brightness_we    = 1'b0;
    brightness_wdata = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every mode, blink edges, pulse corners and the wrap at full scale
    send_sample(32'd0,          MODE_BOOT,        1'b0);
    send_sample(32'hFFFF_FFFF,  MODE_BOOT,        1'b0);
    send_sample(32'd199,        MODE_FAULT_BMS,   1'b0);
    send_sample(32'd200,        MODE_FAULT_BMS,   1'b0);
    send_sample(32'd399,        MODE_FAULT_BMS,   1'b0);
    send_sample(32'd400,        MODE_FAULT_BMS,   1'b0);
    send_sample(32'd399,        MODE_FAULT_MPPT,  1'b0);
    send_sample(32'd400,        MODE_FAULT_MPPT,  1'b0);
    send_sample(32'd800,        MODE_FAULT_MPPT,  1'b0);
    send_sample(32'd12345,      MODE_SOC_LOW,     1'b0);
    send_sample(32'd0,          MODE_SHORE_POWER, 1'b0);
    send_sample(32'd0,          MODE_ACTIVE,      1'b0);
    send_sample(32'd4,          MODE_ACTIVE,      1'b0);
    send_sample(32'd999,        MODE_ACTIVE,      1'b0);
    send_sample(32'd1000,       MODE_ACTIVE,      1'b0);
    send_sample(32'd1001,       MODE_ACTIVE,      1'b0);
    send_sample(32'd1999,       MODE_ACTIVE,      1'b0);
    send_sample(32'd2000,       MODE_ACTIVE,      1'b0);
    send_sample(32'hFFFF_FFFF,  MODE_ACTIVE,      1'b0);
    send_sample(32'd5,          MODE_IDLE_OK,     1'b0);
    send_sample(32'hFFFF_FFFF,  MODE_OFF,         1'b0);
    send_sample(32'd119,        MODE_OFF,         1'b1);
    send_sample(32'd120,        MODE_OFF,         1'b1);
    send_sample(32'd240,        MODE_BOOT,        1'b1);
    send_sample(32'hFFFF_FFFF,  MODE_ACTIVE,      1'b1);
    drain;

    // Random phases, each at its own brightness
    level_plan = '{8'd0, 8'd1, 8'd254, 8'd128, 8'd255, 8'($urandom),
                   8'($urandom), 8'd85};
    for (int p = 0; p < N_PHASES; p++) begin
      write_brightness(level_plan[p]);
      src_burst  = (p % 3 == 1);
      sink_burst = (p % 3 == 2);
      for (int i = 0; i < PHASE_LEN; i++) begin
        mode = mode_t'($urandom_range(0, 7));
        send_sample(pick_time(), mode, $urandom_range(0, 3) == 0);
      end
      drain;
    end

    $display("Checked %0d colour words from %0d samples over %0d brightness writes",
             sb.words, samples, settings);
    $display("Covered all modes, heap alert, blink and pulse edges and the time wrap");
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
